// ----- rtl/btd_pkg.sv -----
`timescale 1ns / 1ps

package btd_pkg;

  // Coordinate and result widths
  localparam int COORD_W       = 16;
  localparam int HEAD_W        = 12;
  // Signed width for the heading fix-up arithmetic
  localparam int SW            = HEAD_W + 2;

  // CORDIC datapath: Q60 operands and angle
  localparam int AW            = 64;
  localparam int ITERS         = 56;
  localparam int OPERAND_SHIFT = 60 - COORD_W;

  // pi in Q60, truncated, and the divisor 2*pi used by the tenths conversion
  localparam logic [AW-1:0] PI_Q60  = 64'h3243F6A8885A308D;
  localparam logic [AW-1:0] DIVISOR = PI_Q60 << 1;

  // Tenths conversion: dividend width and quotient bits
  localparam int DW = 74;
  localparam int QW = 11;

  // Headings in tenths of a degree
  localparam logic [HEAD_W-1:0] HD_ZERO = 12'd0;
  localparam logic [HEAD_W-1:0] HD_UP   = 12'd900;
  localparam logic [HEAD_W-1:0] HD_HALF = 12'd1800;
  localparam logic [HEAD_W-1:0] HD_DOWN = 12'd2700;
  localparam logic [HEAD_W-1:0] HD_FULL = 12'd3600;

  localparam logic [AW-1:0] ONE = 64'd1;

  // atan(2^-i) in Q60: pi/4 for i = 0, else an alternating series of truncated terms
  localparam logic [AW-1:0] ATAN_Q60 [ITERS] = '{
    PI_Q60 >> 2,
    (ONE << 59) - (ONE << 57) / 3 + (ONE << 55) / 5 - (ONE << 53) / 7
      + (ONE << 51) / 9 - (ONE << 49) / 11 + (ONE << 47) / 13 - (ONE << 45) / 15
      + (ONE << 43) / 17 - (ONE << 41) / 19 + (ONE << 39) / 21 - (ONE << 37) / 23
      + (ONE << 35) / 25 - (ONE << 33) / 27 + (ONE << 31) / 29 - (ONE << 29) / 31
      + (ONE << 27) / 33 - (ONE << 25) / 35 + (ONE << 23) / 37 - (ONE << 21) / 39
      + (ONE << 19) / 41 - (ONE << 17) / 43 + (ONE << 15) / 45 - (ONE << 13) / 47
      + (ONE << 11) / 49 - (ONE << 9) / 51 + (ONE << 7) / 53 - (ONE << 5) / 55
      + (ONE << 3) / 57 - (ONE << 1) / 59,
    (ONE << 58) - (ONE << 54) / 3 + (ONE << 50) / 5 - (ONE << 46) / 7
      + (ONE << 42) / 9 - (ONE << 38) / 11 + (ONE << 34) / 13 - (ONE << 30) / 15
      + (ONE << 26) / 17 - (ONE << 22) / 19 + (ONE << 18) / 21 - (ONE << 14) / 23
      + (ONE << 10) / 25 - (ONE << 6) / 27 + (ONE << 2) / 29,
    (ONE << 57) - (ONE << 51) / 3 + (ONE << 45) / 5 - (ONE << 39) / 7
      + (ONE << 33) / 9 - (ONE << 27) / 11 + (ONE << 21) / 13 - (ONE << 15) / 15
      + (ONE << 9) / 17 - (ONE << 3) / 19,
    (ONE << 56) - (ONE << 48) / 3 + (ONE << 40) / 5 - (ONE << 32) / 7
      + (ONE << 24) / 9 - (ONE << 16) / 11 + (ONE << 8) / 13 - ONE / 15,
    (ONE << 55) - (ONE << 45) / 3 + (ONE << 35) / 5 - (ONE << 25) / 7
      + (ONE << 15) / 9 - (ONE << 5) / 11,
    (ONE << 54) - (ONE << 42) / 3 + (ONE << 30) / 5 - (ONE << 18) / 7
      + (ONE << 6) / 9,
    (ONE << 53) - (ONE << 39) / 3 + (ONE << 25) / 5 - (ONE << 11) / 7,
    (ONE << 52) - (ONE << 36) / 3 + (ONE << 20) / 5 - (ONE << 4) / 7,
    (ONE << 51) - (ONE << 33) / 3 + (ONE << 15) / 5,
    (ONE << 50) - (ONE << 30) / 3 + (ONE << 10) / 5,
    (ONE << 49) - (ONE << 27) / 3 + (ONE << 5) / 5,
    (ONE << 48) - (ONE << 24) / 3 + ONE / 5,
    (ONE << 47) - (ONE << 21) / 3,
    (ONE << 46) - (ONE << 18) / 3,
    (ONE << 45) - (ONE << 15) / 3,
    (ONE << 44) - (ONE << 12) / 3,
    (ONE << 43) - (ONE << 9) / 3,
    (ONE << 42) - (ONE << 6) / 3,
    (ONE << 41) - (ONE << 3) / 3,
    (ONE << 40) - ONE / 3,
    ONE << 39, ONE << 38, ONE << 37, ONE << 36, ONE << 35, ONE << 34, ONE << 33,
    ONE << 32, ONE << 31, ONE << 30, ONE << 29, ONE << 28, ONE << 27, ONE << 26,
    ONE << 25, ONE << 24, ONE << 23, ONE << 22, ONE << 21, ONE << 20, ONE << 19,
    ONE << 18, ONE << 17, ONE << 16, ONE << 15, ONE << 14, ONE << 13, ONE << 12,
    ONE << 11, ONE << 10, ONE << 9, ONE << 8, ONE << 7, ONE << 6, ONE << 5
  };

  // Per-request sideband that rides along the pipeline
  typedef struct packed {
    logic              left;     // dx negative: add a half turn at the end
    logic              spec;     // dx zero: heading taken from spec_hd
    logic [HEAD_W-1:0] spec_hd;
    logic              zneg;     // CORDIC angle negative
  } sb_t;

endpackage

// ----- rtl/bearing_to_destination.sv -----
`timescale 1ns / 1ps

// Heading from a start point to a destination point, in tenths of a degree
// (0..3599, counterclockwise from +x).
//
// Input channel: in_valid / in_stall with the four signed coordinates; a
// request is taken at a clock edge with in_valid high and in_stall low.
// Output channel: out_valid / out_stall with out_heading.
//
// Throughput: one request per cycle while in_stall is low. The pipeline has
// one stage for the difference and operand setup, one stage per CORDIC
// iteration (56), one for the angle magnitude, one for the scaled dividend,
// one per quotient bit of the radians-to-tenths division (11), and the
// output register.
//
// Reset (rst_n low, synchronous) empties the pipeline and the output side.
// When the receiver stalls, the result holds in the output register; one more
// result goes into a skid register, after which in_stall rises and the whole
// pipeline holds until the skid register drains.
module bearing_to_destination (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic signed [btd_pkg::COORD_W-1:0] in_start_x,
  input  logic signed [btd_pkg::COORD_W-1:0] in_start_y,
  input  logic signed [btd_pkg::COORD_W-1:0] in_dest_x,
  input  logic signed [btd_pkg::COORD_W-1:0] in_dest_y,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [btd_pkg::HEAD_W-1:0]        out_heading
);

  // Pipeline advance enable
  logic en;

  // Operand setup
  logic signed [btd_pkg::COORD_W:0]   dx, dy;
  logic [btd_pkg::COORD_W:0]          ux;
  logic signed [btd_pkg::COORD_W+1:0] dy_ext, vy;
  logic                               left;
  logic [btd_pkg::HEAD_W-1:0]         spec_hd;

  // CORDIC stages
  logic [btd_pkg::ITERS:0]            cv_r;
  logic signed [btd_pkg::AW-1:0]      cx_r   [0:btd_pkg::ITERS];
  logic signed [btd_pkg::AW-1:0]      cy_r   [0:btd_pkg::ITERS];
  logic signed [btd_pkg::AW-1:0]      cz_r   [0:btd_pkg::ITERS];
  logic signed [btd_pkg::AW-1:0]      cx_nxt [0:btd_pkg::ITERS];
  logic signed [btd_pkg::AW-1:0]      cy_nxt [0:btd_pkg::ITERS];
  logic signed [btd_pkg::AW-1:0]      cz_nxt [0:btd_pkg::ITERS];
  btd_pkg::sb_t                       sbc_r  [0:btd_pkg::ITERS];
  btd_pkg::sb_t                       sbc_nxt;

  // Magnitude stage
  logic                               mv_r;
  logic [btd_pkg::AW-1:0]             mag_r, mag_nxt;
  btd_pkg::sb_t                       sbm_r, sbm_nxt;

  // Division stages
  logic [btd_pkg::QW:0]               dv_r;
  logic [btd_pkg::DW-1:0]             dr_r   [0:btd_pkg::QW-1];
  logic [btd_pkg::DW-1:0]             dr_nxt [0:btd_pkg::QW-1];
  logic [btd_pkg::QW-1:0]             dq_r   [1:btd_pkg::QW];
  logic [btd_pkg::QW-1:0]             dq_nxt [1:btd_pkg::QW];
  btd_pkg::sb_t                       sbd_r  [0:btd_pkg::QW];

  // Final fix-up
  logic signed [btd_pkg::SW-1:0]      qs, a0, a1, a2, a3, half_s, full_s;
  btd_pkg::sb_t                       sbf;
  logic [btd_pkg::HEAD_W-1:0]         fin_hd;

  // Output side
  logic                               out_valid_r, skid_v_r;
  logic [btd_pkg::HEAD_W-1:0]         out_hd_r, skid_hd_r;
  logic                               last_v;

  assign en       = !skid_v_r;
  assign in_stall = skid_v_r;

  // Form the differences and fold the vector into the right half plane
  assign dx     = {in_dest_x[btd_pkg::COORD_W-1], in_dest_x}
                - {in_start_x[btd_pkg::COORD_W-1], in_start_x};
  assign dy     = {in_dest_y[btd_pkg::COORD_W-1], in_dest_y}
                - {in_start_y[btd_pkg::COORD_W-1], in_start_y};
  assign left   = dx[btd_pkg::COORD_W];
  assign ux     = left ? -dx : dx;
  assign dy_ext = {dy[btd_pkg::COORD_W], dy};
  assign vy     = left ? -dy_ext : dy_ext;

  // Pick the heading for a vertical or zero vector
  always_comb begin
    if (dy == '0) begin
      spec_hd = btd_pkg::HD_ZERO;
    end else if (dy[btd_pkg::COORD_W]) begin
      spec_hd = btd_pkg::HD_DOWN;
    end else begin
      spec_hd = btd_pkg::HD_UP;
    end
  end

  assign cx_nxt[0] = $signed(btd_pkg::AW'(ux) << btd_pkg::OPERAND_SHIFT);
  assign cy_nxt[0] = btd_pkg::AW'(vy) <<< btd_pkg::OPERAND_SHIFT;
  assign cz_nxt[0] = '0;

  always_comb begin
    sbc_nxt         = '0;
    sbc_nxt.left    = left;
    sbc_nxt.spec    = (dx == '0);
    sbc_nxt.spec_hd = spec_hd;
  end

  // One vectoring CORDIC iteration per stage
  for (genvar i = 0; i < btd_pkg::ITERS; i++) begin : g_cordic
    logic signed [btd_pkg::AW-1:0] xs, ys, t;
    assign xs = cx_r[i] >>> i;
    assign ys = cy_r[i] >>> i;
    assign t  = $signed(btd_pkg::ATAN_Q60[i]);
    assign cx_nxt[i+1] = cy_r[i][btd_pkg::AW-1] ? cx_r[i] - ys : cx_r[i] + ys;
    assign cy_nxt[i+1] = cy_r[i][btd_pkg::AW-1] ? cy_r[i] + xs : cy_r[i] - xs;
    assign cz_nxt[i+1] = cy_r[i][btd_pkg::AW-1] ? cz_r[i] - t : cz_r[i] + t;
  end

  // Take the angle magnitude and remember its sign
  always_comb begin
    mag_nxt      = cz_r[btd_pkg::ITERS][btd_pkg::AW-1] ? btd_pkg::AW'(-cz_r[btd_pkg::ITERS])
                                                       : btd_pkg::AW'(cz_r[btd_pkg::ITERS]);
    sbm_nxt      = sbc_r[btd_pkg::ITERS];
    sbm_nxt.zneg = cz_r[btd_pkg::ITERS][btd_pkg::AW-1];
  end

  // Rounded tenths = floor((3600 * |z| + pi) / (2 * pi)), one quotient bit per stage
  assign dr_nxt[0] = btd_pkg::DW'(mag_r) * btd_pkg::DW'(btd_pkg::HD_FULL)
                   + btd_pkg::DW'(btd_pkg::PI_Q60);

  for (genvar j = 0; j < btd_pkg::QW; j++) begin : g_div
    localparam logic [btd_pkg::DW-1:0] TRIAL =
      btd_pkg::DW'(btd_pkg::DIVISOR) << (btd_pkg::QW - 1 - j);
    logic                   ge;
    logic [btd_pkg::QW-1:0] qin;
    assign ge = (dr_r[j] >= TRIAL);
    if (j == 0) begin : g_first
      assign qin = '0;
    end else begin : g_rest
      assign qin = dq_r[j];
    end
    assign dq_nxt[j+1] = {qin[btd_pkg::QW-2:0], ge};
    if (j < btd_pkg::QW - 1) begin : g_rem
      assign dr_nxt[j+1] = ge ? dr_r[j] - TRIAL : dr_r[j];
    end
  end

  // Advance valid bits; clear them at reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cv_r <= '0;
      mv_r <= 1'b0;
      dv_r <= '0;
    end else if (en) begin
      cv_r <= {cv_r[btd_pkg::ITERS-1:0], in_valid};
      mv_r <= cv_r[btd_pkg::ITERS];
      dv_r <= {dv_r[btd_pkg::QW-1:0], mv_r};
    end
  end

  // Advance payload with the valid bits
  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k <= btd_pkg::ITERS; k++) begin
        cx_r[k] <= cx_nxt[k];
        cy_r[k] <= cy_nxt[k];
        cz_r[k] <= cz_nxt[k];
      end
      sbc_r[0] <= sbc_nxt;
      for (int k = 1; k <= btd_pkg::ITERS; k++) begin
        sbc_r[k] <= sbc_r[k-1];
      end
      mag_r <= mag_nxt;
      sbm_r <= sbm_nxt;
      for (int k = 0; k < btd_pkg::QW; k++) begin
        dr_r[k] <= dr_nxt[k];
      end
      for (int k = 1; k <= btd_pkg::QW; k++) begin
        dq_r[k] <= dq_nxt[k];
      end
      sbd_r[0] <= sbm_r;
      for (int k = 1; k <= btd_pkg::QW; k++) begin
        sbd_r[k] <= sbd_r[k-1];
      end
    end
  end

  // Apply sign, half turn and wrap; vertical and zero-length cases override
  assign sbf    = sbd_r[btd_pkg::QW];
  assign half_s = $signed(btd_pkg::SW'(btd_pkg::HD_HALF));
  assign full_s = $signed(btd_pkg::SW'(btd_pkg::HD_FULL));
  assign qs     = $signed(btd_pkg::SW'(dq_r[btd_pkg::QW]));
  assign a0     = sbf.zneg ? -qs : qs;
  assign a1     = sbf.left ? a0 + half_s : a0;
  assign a2     = a1[btd_pkg::SW-1] ? a1 + full_s : a1;
  assign a3     = (a2 >= full_s) ? a2 - full_s : a2;
  assign fin_hd = sbf.spec ? sbf.spec_hd : a3[btd_pkg::HEAD_W-1:0];

  assign last_v = dv_r[btd_pkg::QW];

  // Output register with skid: drain skid first, else load or park the new result
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      skid_v_r    <= 1'b0;
    end else begin
      priority if (skid_v_r) begin
        if (!out_stall) begin
          skid_v_r <= 1'b0;
        end
      end else if (!out_valid_r || !out_stall) begin
        out_valid_r <= last_v;
      end else begin
        skid_v_r <= last_v;
      end
    end
  end

  always_ff @(posedge clk) begin
    priority if (skid_v_r) begin
      if (!out_stall) begin
        out_hd_r <= skid_hd_r;
      end
    end else if (!out_valid_r || !out_stall) begin
      out_hd_r <= fin_hd;
    end else begin
      skid_hd_r <= fin_hd;
    end
  end

  assign out_valid   = out_valid_r;
  assign out_heading = out_hd_r;

endmodule

// ----- rtl/btd_checker.sv -----
`timescale 1ns / 1ps

module btd_checker (
  input logic                       clk,
  input logic                       rst_n,
  input logic                       in_valid,
  input logic                       in_stall,
  input logic                       out_valid,
  input logic                       out_stall,
  input logic [btd_pkg::HEAD_W-1:0] out_heading
);

  // Hold a stalled result
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_heading))
    else $error("stalled result changed or dropped");

  // Keep every heading below a full turn
  a_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_heading < btd_pkg::HD_FULL))
    else $error("heading out of range");

  // Raise input stall only with a result waiting at the output
  a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid)
    else $error("input stalled with empty output");

  // Raise input stall only after the receiver stalled a waiting result
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> $past(out_valid && out_stall))
    else $error("input stalled without output backpressure");

endmodule

bind bearing_to_destination btd_checker u_btd_checker (.*);

// ----- tb/heading_checker.sv -----
`timescale 1ns / 1ps

module heading_checker (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  input  logic                               in_stall,
  input  logic signed [btd_pkg::COORD_W-1:0] in_start_x,
  input  logic signed [btd_pkg::COORD_W-1:0] in_start_y,
  input  logic signed [btd_pkg::COORD_W-1:0] in_dest_x,
  input  logic signed [btd_pkg::COORD_W-1:0] in_dest_y,
  input  logic                               out_valid,
  input  logic                               out_stall,
  input  logic [btd_pkg::HEAD_W-1:0]         out_heading,
  output int                                 mismatches,
  output int                                 outstanding
);
  import btd_pkg::*;

  localparam int ANGLE_FRAC_BITS = 24;
  localparam int MAX_REPORTS     = 10;

  typedef struct {
    logic signed [COORD_W-1:0] sx, sy, tx, ty;
    logic [HEAD_W-1:0]         heading;
  } pending_t;

  pending_t pending_headings[$];
  longint   atan_step[ITERS];

  // atan(2^-i) in Q60: pi/4 for i = 0, else the truncated alternating series
  function automatic longint atan_of_pow2(input int i);
    longint acc;
    int     k;
    int     e;
    acc = 0;
    if (i == 0) return longint'(PI_Q60 >> 2);
    for (k = 0; 60 - i * (2 * k + 1) >= 0; k++) begin
      e = 60 - i * (2 * k + 1);
      if (k % 2 == 1) acc -= longint'((64'd1 << e) / (2 * k + 1));
      else acc += longint'((64'd1 << e) / (2 * k + 1));
    end
    return acc;
  endfunction

  // Heading of (dest - start) in tenths, vectoring CORDIC in Q60
  function automatic logic [HEAD_W-1:0] predict_heading(
    input logic signed [COORD_W-1:0] sx, sy, tx, ty);
    longint      dx, dy, x, y, z, xs, ys;
    logic [63:0] mag, quot, tenths;
    logic [127:0] scaled;
    int          a;
    bit          left;
    dx = longint'(tx) - longint'(sx);
    dy = longint'(ty) - longint'(sy);
    if (dx == 0) begin
      if (dy > 0) a = int'(HD_UP);
      else if (dy < 0) a = int'(HD_DOWN);
      else a = int'(HD_ZERO);
    end else begin
      left = (dx < 0);
      // mirror the left half plane so the angle is atan(dy/dx)
      x = (left ? -dx : dx) <<< OPERAND_SHIFT;
      y = (left ? -dy : dy) <<< OPERAND_SHIFT;
      z = 0;
      for (int i = 0; i < ITERS; i++) begin
        xs = x >>> i;
        ys = y >>> i;
        if (y >= 0) begin
          x += ys;
          y -= xs;
          z += atan_step[i];
        end else begin
          x -= ys;
          y += xs;
          z -= atan_step[i];
        end
      end
      // radians to tenths, truncated, then round half away from zero
      mag    = (z < 0) ? 64'(-z) : 64'(z);
      scaled = ({64'd0, mag} * 128'd1800) << ANGLE_FRAC_BITS;
      quot   = 64'(scaled / {64'd0, PI_Q60});
      tenths = (quot + (64'd1 << (ANGLE_FRAC_BITS - 1))) >> ANGLE_FRAC_BITS;
      a = (z < 0) ? -int'(tenths) : int'(tenths);
      if (left) a += int'(HD_HALF);
      if (a < 0) a += int'(HD_FULL);
      if (a >= int'(HD_FULL)) a -= int'(HD_FULL);
    end
    return a[HEAD_W-1:0];
  endfunction

  initial begin
    mismatches  = 0;
    outstanding = 0;
    for (int i = 0; i < ITERS; i++) atan_step[i] = atan_of_pow2(i);
  end

  // Queue a prediction per accepted request, compare each accepted result
  always @(posedge clk) begin
    pending_t p;
    if (rst_n) begin
      if (in_valid && !in_stall) begin
        p.sx = in_start_x;
        p.sy = in_start_y;
        p.tx = in_dest_x;
        p.ty = in_dest_y;
        p.heading = predict_heading(in_start_x, in_start_y, in_dest_x, in_dest_y);
        pending_headings.push_back(p);
      end
      if (out_valid && !out_stall) begin
        if (pending_headings.size() == 0) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS)
            $display("%0t: unexpected heading %0d with no request pending",
                     $realtime, out_heading);
        end else begin
          p = pending_headings.pop_front();
          if (out_heading !== p.heading) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS)
              $display("%0t: heading (%0d,%0d)->(%0d,%0d) expected %0d got %0d",
                       $realtime, p.sx, p.sy, p.tx, p.ty, p.heading, out_heading);
          end
        end
      end
    end
    outstanding = pending_headings.size();
  end

endmodule

// ----- tb/tb_top.sv -----
`timescale 1ns / 1ps

module tb_top;
  import btd_pkg::*;

  localparam int RESET_CYCLES = 7;
  localparam int RANDOM_ITEMS = 700;
  localparam int MAX_GAP      = 8;
  localparam int LONG_HOLD    = 1000;
  localparam int DRAIN_CYCLES = 150;
  localparam int QUIET_LIMIT  = 5000;

  typedef enum int {SH_WIDE, SH_NEAR, SH_VERT, SH_HORIZ, SH_DIAG, SH_SAME, SH_CORNER} shape_t;

  logic clk = 1'b0;
  logic rst_n;
  logic in_valid;
  logic in_stall;
  logic signed [COORD_W-1:0] in_start_x, in_start_y, in_dest_x, in_dest_y;
  logic out_valid;
  logic out_stall;
  logic [HEAD_W-1:0] out_heading;
  int   mismatches;
  int   outstanding;
  int   quiet_cycles;
  bit   idle_on;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  bearing_to_destination DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_start_x (in_start_x),
    .in_start_y (in_start_y),
    .in_dest_x  (in_dest_x),
    .in_dest_y  (in_dest_y),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_heading(out_heading)
  );

  heading_checker u_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_start_x (in_start_x),
    .in_start_y (in_start_y),
    .in_dest_x  (in_dest_x),
    .in_dest_y  (in_dest_y),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_heading(out_heading),
    .mismatches (mismatches),
    .outstanding(outstanding)
  );

  // Called at a falling edge; returns at the falling edge after acceptance
  task automatic send_request(input logic signed [COORD_W-1:0] sx, sy, tx, ty,
                              input int gap);
    if (gap > 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid   = 1'b1;
    in_start_x = sx;
    in_start_y = sy;
    in_dest_x  = tx;
    in_dest_y  = ty;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
  endtask

  function automatic logic signed [COORD_W-1:0] corner_value();
    case ($urandom_range(0, 3))
      0: return 16'sh8000;
      1: return 16'sh7fff;
      2: return 16'sh0000;
      default: return 16'shffff;
    endcase
  endfunction

  // Draw a request: wide random most often, with near, axis, diagonal and corner shapes
  task automatic pick_request(output logic signed [COORD_W-1:0] sx, sy, tx, ty);
    shape_t shape;
    int     d;
    case ($urandom_range(0, 11))
      0, 1, 2, 3: shape = SH_WIDE;
      4, 5:       shape = SH_NEAR;
      6:          shape = SH_VERT;
      7:          shape = SH_HORIZ;
      8, 9:       shape = SH_DIAG;
      10:         shape = SH_SAME;
      default:    shape = SH_CORNER;
    endcase
    sx = COORD_W'($urandom);
    sy = COORD_W'($urandom);
    tx = COORD_W'($urandom);
    ty = COORD_W'($urandom);
    d  = $urandom_range(0, 1000);
    case (shape)
      SH_NEAR: begin
        tx = COORD_W'(sx + $signed($urandom_range(0, 8)) - 4);
        ty = COORD_W'(sy + $signed($urandom_range(0, 8)) - 4);
      end
      SH_VERT:  tx = sx;
      SH_HORIZ: ty = sy;
      SH_DIAG: begin
        tx = COORD_W'($urandom_range(0, 1) ? sx + d : sx - d);
        ty = COORD_W'($urandom_range(0, 1) ? sy + d : sy - d);
      end
      SH_SAME: begin
        tx = sx;
        ty = sy;
      end
      SH_CORNER: begin
        sx = corner_value();
        sy = corner_value();
        tx = corner_value();
        ty = corner_value();
      end
      default: ;
    endcase
  endtask

  // Result side: per-result stall, with two long hold-offs to fill the pipeline
  initial begin : receiver
    int n;
    int taken;
    out_stall = 1'b0;
    taken = 0;
    @(posedge rst_n);
    @(negedge clk);
    forever begin
      n = idle_on ? $urandom_range(0, MAX_GAP) : 0;
      if (taken == 100 || taken == 450) n += LONG_HOLD;
      if (n > 0) begin
        out_stall = 1'b1;
        repeat (n) @(negedge clk);
      end
      out_stall = 1'b0;
      do @(posedge clk); while (!out_valid);
      taken++;
      @(negedge clk);
    end
  end

  // Stimulus and verdict
  initial begin
    logic signed [COORD_W-1:0] sx, sy, tx, ty;
    rst_n      = 1'b0;
    in_valid   = 1'b0;
    in_start_x = '0;
    in_start_y = '0;
    in_dest_x  = '0;
    in_dest_y  = '0;
    idle_on    = 1'b1;
    repeat (RESET_CYCLES) @(negedge clk);
    rst_n = 1'b1;

    // Directed: axes, identical points, extremes, each quadrant
    send_request(16'sd0, 16'sd0, 16'sd0, 16'sd0, 0);
    send_request(16'sd0, 16'sd0, 16'sd0, 16'sd5, 1);
    send_request(16'sd0, 16'sd0, 16'sd0, -16'sd5, 0);
    send_request(16'sd0, -16'sd32768, 16'sd0, 16'sd32767, 2);
    send_request(16'sd0, 16'sd32767, 16'sd0, -16'sd32768, 0);
    send_request(16'sd12, 16'sd7, 16'sd12, 16'sd7, 0);
    send_request(16'sd0, 16'sd0, 16'sd9, 16'sd0, 3);
    send_request(16'sd0, 16'sd0, -16'sd9, 16'sd0, 0);
    send_request(-16'sd32768, -16'sd32768, 16'sd32767, 16'sd32767, 0);
    send_request(16'sd32767, 16'sd32767, -16'sd32768, -16'sd32768, 1);
    send_request(-16'sd32768, 16'sd32767, 16'sd32767, -16'sd32768, 0);
    send_request(16'sd32767, -16'sd32768, -16'sd32768, 16'sd32767, 0);
    send_request(16'sd0, 16'sd0, 16'sd1, 16'sd1, 4);
    send_request(16'sd0, 16'sd0, 16'sd1, -16'sd1, 0);
    send_request(16'sd0, 16'sd0, -16'sd1, 16'sd1, 0);
    send_request(16'sd0, 16'sd0, -16'sd1, -16'sd1, 0);
    send_request(-16'sd32768, 16'sd0, 16'sd32767, 16'sd1, 0);
    send_request(16'sd0, -16'sd32768, 16'sd1, 16'sd32767, 2);
    send_request(16'sd32767, 16'sd0, -16'sd32768, -16'sd1, 0);
    send_request(16'sd0, 16'sd32767, -16'sd1, -16'sd32768, 0);
    send_request(16'sd100, 16'sd100, 16'sd373, 16'sd227, 0);
    send_request(16'sd0, 16'sd0, 16'sd1000, -16'sd1, 8);

    // Random: segments with and without idling, one pause to drain
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      if (i % 50 == 0) idle_on = ($urandom_range(0, 3) != 0);
      if (i == 300) begin
        in_valid = 1'b0;
        while (outstanding != 0) @(negedge clk);
      end
      pick_request(sx, sy, tx, ty);
      send_request(sx, sy, tx, ty, idle_on ? $urandom_range(0, MAX_GAP) : 0);
    end
    in_valid = 1'b0;

    // Drain, then let the pipeline settle
    while (outstanding != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (mismatches == 0 && outstanding == 0) $display("Simulation PASSED");
    else $display("Simulation FAILED");
    $finish;
  end

  // Watchdog: end the run if neither channel moves for too long
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

endmodule
